@@ hw/rtl/uttrb_pkg.sv @@
// Package for the buffered UART data path: event and result payload types,
// operation codes and status codes. No dependencies.
`default_nettype none

package uttrb_pkg;

  // Event operation codes.
  localparam logic [2:0] OP_TX_RESERVE = 3'd0;
  localparam logic [2:0] OP_TX_PUSH    = 3'd1;
  localparam logic [2:0] OP_TX_DONE    = 3'd2;
  localparam logic [2:0] OP_RX_BYTE    = 3'd3;
  localparam logic [2:0] OP_RX_READ    = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Width of the level fields in a result.
  localparam int unsigned LevelWidth = 6;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data;
    logic [7:0] count;
  } evt_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [7:0]            read_data;
    logic                  line_valid;
    logic [7:0]            line_byte;
    logic                  tx_busy;
    logic [LevelWidth-1:0] tx_level;
    logic [LevelWidth-1:0] rx_level;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/uttrb_if.sv @@
// Valid/ready channel interfaces for event beats and result beats.
// Depends on uttrb_pkg for the payload types.
`default_nettype none

interface uttrb_evt_if;
  logic              valid;
  logic              ready;
  uttrb_pkg::evt_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface uttrb_res_if;
  logic              valid;
  logic              ready;
  uttrb_pkg::res_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/uart_tx_rx_ring_buffers.sv @@
// Top level of the buffered UART data path with transmit and receive ring queues.
// Depends on uttrb_pkg and the channel interfaces in uttrb_if.sv.
`default_nettype none

// Each event beat on evt_i (reserve, push, transmitter done, received byte,
// read) produces exactly one result beat on res_o. Both queues live in
// synchronous memories of 2^BUFFER_LOG2 bytes with registered read data and
// hold at most one entry less than that, so equal indices mean empty. An event
// passes through the idle and execute states: in the accept cycle both memories
// are read at their current read indices, and in the next cycle the event is
// evaluated, the write goes back to the memory and the indices move. The result
// lands in an output register, so a new event is accepted as soon as the block
// is back in its idle state and the result register is empty or being drained
// in that same cycle; no new event is taken while one is being executed. The
// only read that can hit an entry being written in the same event is a push to
// an idle transmitter with an empty queue; that byte is forwarded straight from
// the event instead of from the memory. Memory contents need no reset, since an
// entry is only ever read after it was written; no clearing pass is run. Levels
// are reported in 6 bits, truncated when BUFFER_LOG2 exceeds 6.

module uart_tx_rx_ring_buffers #(
  parameter int unsigned BUFFER_LOG2 = 6
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  uttrb_evt_if.sink    evt_i,
  uttrb_res_if.source  res_o
);

  localparam int unsigned Depth = 1 << BUFFER_LOG2;
  localparam logic [BUFFER_LOG2-1:0] Capacity = {BUFFER_LOG2{1'b1}};
  localparam logic [BUFFER_LOG2-1:0] IdxOne   = BUFFER_LOG2'(1);
  localparam logic [BUFFER_LOG2-1:0] IdxZero  = '0;

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;

  // Queue indices and transmitter flag.
  logic [BUFFER_LOG2-1:0] tx_wr_q, tx_rd_q, rx_wr_q, rx_rd_q;
  logic                   sending_q;

  // Captured event and registered memory read data.
  uttrb_pkg::evt_t        evt_q;
  logic [7:0]             tx_rdata_q, rx_rdata_q;

  // Output register.
  logic                   res_valid_q;
  uttrb_pkg::res_t        res_q;

  logic [7:0] tx_mem [Depth];
  logic [7:0] rx_mem [Depth];

  logic evt_accept;
  assign evt_i.ready = (state_q == StIdle) && (!res_valid_q || res_o.ready);
  assign evt_accept  = evt_i.valid && evt_i.ready;

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  // ---------------------------------------------------------------------------
  // Evaluation of the captured event, done in the execute cycle.
  // ---------------------------------------------------------------------------
  logic [BUFFER_LOG2-1:0] tx_lvl, rx_lvl, tx_free, tx_wr_d, tx_rd_d, rx_wr_d, rx_rd_d;
  logic [BUFFER_LOG2-1:0] tx_lvl_put;
  logic                   tx_put_ok, rx_put_ok, tx_we, rx_we, sending_d;
  logic                   take_tx;
  logic [BUFFER_LOG2+7:0] free_ext, count_ext;
  logic [BUFFER_LOG2+7:0] tx_lvl_ext, rx_lvl_ext;
  uttrb_pkg::res_t        res_d;

  always_comb begin
    tx_lvl    = tx_wr_q - tx_rd_q;
    rx_lvl    = rx_wr_q - rx_rd_q;
    tx_free   = Capacity - tx_lvl;
    free_ext  = {8'd0, tx_free};
    count_ext = {{BUFFER_LOG2{1'b0}}, evt_q.count};
    tx_put_ok = (tx_lvl != Capacity);
    rx_put_ok = (rx_lvl != Capacity);

    tx_wr_d    = tx_wr_q;
    tx_rd_d    = tx_rd_q;
    rx_wr_d    = rx_wr_q;
    rx_rd_d    = rx_rd_q;
    sending_d  = sending_q;
    tx_we      = 1'b0;
    rx_we      = 1'b0;
    take_tx    = 1'b0;
    tx_lvl_put = tx_lvl;

    res_d            = '0;
    res_d.status     = uttrb_pkg::ST_OK;

    case (evt_q.operation)
      uttrb_pkg::OP_TX_RESERVE: begin
        if (free_ext < count_ext) begin
          res_d.status = uttrb_pkg::ST_NO_SPACE;
        end
      end
      uttrb_pkg::OP_TX_PUSH: begin
        if (tx_put_ok) begin
          tx_we      = 1'b1;
          tx_wr_d    = tx_wr_q + IdxOne;
          tx_lvl_put = tx_lvl + IdxOne;
        end else begin
          res_d.status = uttrb_pkg::ST_FULL;
        end
        if (!sending_q) begin
          sending_d = 1'b1;
          take_tx   = (tx_lvl_put != IdxZero);
        end
      end
      uttrb_pkg::OP_TX_DONE: begin
        take_tx   = (tx_lvl != IdxZero);
        sending_d = take_tx;
      end
      uttrb_pkg::OP_RX_BYTE: begin
        if (rx_put_ok) begin
          rx_we   = 1'b1;
          rx_wr_d = rx_wr_q + IdxOne;
        end else begin
          res_d.status = uttrb_pkg::ST_FULL;
        end
      end
      uttrb_pkg::OP_RX_READ: begin
        if (rx_lvl != IdxZero) begin
          res_d.read_data = rx_rdata_q;
          rx_rd_d         = rx_rd_q + IdxOne;
        end else begin
          res_d.status = uttrb_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase

    if (take_tx) begin
      tx_rd_d          = tx_rd_q + IdxOne;
      res_d.line_valid = 1'b1;
      // The entry just written is the one being taken: forward the event byte.
      res_d.line_byte  = (tx_we && (tx_rd_q == tx_wr_q)) ? evt_q.data : tx_rdata_q;
    end

    tx_lvl_ext     = {8'd0, BUFFER_LOG2'(tx_wr_d - tx_rd_d)};
    rx_lvl_ext     = {8'd0, BUFFER_LOG2'(rx_wr_d - rx_rd_d)};
    res_d.tx_busy  = sending_d;
    res_d.tx_level = tx_lvl_ext[uttrb_pkg::LevelWidth-1:0];
    res_d.rx_level = rx_lvl_ext[uttrb_pkg::LevelWidth-1:0];
  end

  // ---------------------------------------------------------------------------
  // Control state, indices and output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tx_wr_q     <= '0;
      tx_rd_q     <= '0;
      rx_wr_q     <= '0;
      rx_rd_q     <= '0;
      sending_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (evt_accept) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          tx_wr_q     <= tx_wr_d;
          tx_rd_q     <= tx_rd_d;
          rx_wr_q     <= rx_wr_d;
          rx_rd_q     <= rx_rd_d;
          sending_q   <= sending_d;
          res_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (evt_accept) begin
      evt_q <= evt_i.payload;
    end
    if (state_q == StExec) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Queue memories: read at the read index in the accept cycle, written in the
  // execute cycle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (evt_accept) begin
      tx_rdata_q <= tx_mem[tx_rd_q];
    end
    if ((state_q == StExec) && tx_we) begin
      tx_mem[tx_wr_q] <= evt_q.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_accept) begin
      rx_rdata_q <= rx_mem[rx_rd_q];
    end
    if ((state_q == StExec) && rx_we) begin
      rx_mem[rx_wr_q] <= evt_q.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // An idle transmitter never leaves bytes waiting in the transmit queue.
  a_idle_tx_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (tx_wr_q == tx_rd_q))
    else $error("transmitter idle with a nonempty transmit queue");

  // A byte handed to the line always leaves the transmitter running.
  a_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.line_valid) |-> res_q.tx_busy)
    else $error("byte sent while the transmitter reads as idle");

  // Every accepted event moves to the execute state and then has a loaded result.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_accept |=> (state_q == StExec) ##1 res_valid_q)
    else $error("accepted event did not produce a result");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the buffered UART data path with ring queues.
// Depends on uttrb_pkg, the channel interfaces in uttrb_if.sv and the top
// level uart_tx_rx_ring_buffers.
`timescale 1ns / 1ps

module testbench;

  // The block is built with the default buffer of 64 entries, so each queue
  // holds at most 63 bytes and the 6-bit level fields never truncate.
  localparam int unsigned RingLog2 = 6;
  localparam int unsigned RingCap  = (1 << RingLog2) - 1;
  localparam int unsigned RandomEvents = 1900;
  localparam int unsigned MaxReports   = 10;

  // One row of the directed table. When typed is set, want is the result
  // typed in by hand; otherwise the result comes from the ring buffer
  // predictor.
  typedef struct packed {
    uttrb_pkg::evt_t ev;
    logic            typed;
    uttrb_pkg::res_t want;
  } stim_row_t;

  // Traffic shapes for the random part. Each episode but MIXED leans on one
  // queue so that both queues run into full and empty over and over.
  typedef enum logic [2:0] {
    FILL_TX, DRAIN_TX, FILL_RX, DRAIN_RX, MIXED
  } traffic_mode_e;

  localparam uttrb_pkg::res_t NoRes = '0;
  localparam int unsigned DirectedRows = 24;

  // Fields in a typed result: status, read_data, line_valid, line_byte,
  // tx_busy, tx_level, rx_level.
  localparam stim_row_t Directed [DirectedRows] = '{
    // Reads and reserves on the empty queues just after reset.
    {uttrb_pkg::OP_RX_READ,    8'h00, 8'h00, 1'b1,
     uttrb_pkg::ST_EMPTY,    8'h00, 1'b0, 8'h00, 1'b0, 6'd0, 6'd0},
    {uttrb_pkg::OP_TX_RESERVE, 8'h00, 8'd63, 1'b1,
     uttrb_pkg::ST_OK,       8'h00, 1'b0, 8'h00, 1'b0, 6'd0, 6'd0},
    {uttrb_pkg::OP_TX_RESERVE, 8'h00, 8'd64, 1'b1,
     uttrb_pkg::ST_NO_SPACE, 8'h00, 1'b0, 8'h00, 1'b0, 6'd0, 6'd0},
    {uttrb_pkg::OP_TX_RESERVE, 8'hFF, 8'hFF, 1'b1,
     uttrb_pkg::ST_NO_SPACE, 8'h00, 1'b0, 8'h00, 1'b0, 6'd0, 6'd0},
    {uttrb_pkg::OP_TX_RESERVE, 8'h00, 8'h00, 1'b1,
     uttrb_pkg::ST_OK,       8'h00, 1'b0, 8'h00, 1'b0, 6'd0, 6'd0},
    // A transmitter done with nothing queued leaves the line idle.
    {uttrb_pkg::OP_TX_DONE,    8'h00, 8'h00, 1'b1,
     uttrb_pkg::ST_OK,       8'h00, 1'b0, 8'h00, 1'b0, 6'd0, 6'd0},
    // A push to the idle transmitter goes straight out on the line.
    {uttrb_pkg::OP_TX_PUSH,    8'hFF, 8'h00, 1'b1,
     uttrb_pkg::ST_OK,       8'h00, 1'b1, 8'hFF, 1'b1, 6'd0, 6'd0},
    // Further pushes while busy only queue.
    {uttrb_pkg::OP_TX_PUSH,    8'h00, 8'hFF, 1'b1,
     uttrb_pkg::ST_OK,       8'h00, 1'b0, 8'h00, 1'b1, 6'd1, 6'd0},
    {uttrb_pkg::OP_TX_PUSH,    8'h5A, 8'h00, 1'b0, NoRes},
    // Reserve right at the edge of the free space, then one past it.
    {uttrb_pkg::OP_TX_RESERVE, 8'h00, 8'd61, 1'b0, NoRes},
    {uttrb_pkg::OP_TX_RESERVE, 8'h00, 8'd62, 1'b0, NoRes},
    // Drain the queue one done at a time, then go idle.
    {uttrb_pkg::OP_TX_DONE,    8'hFF, 8'h00, 1'b0, NoRes},
    {uttrb_pkg::OP_TX_DONE,    8'h00, 8'h00, 1'b0, NoRes},
    {uttrb_pkg::OP_TX_DONE,    8'h00, 8'h00, 1'b0, NoRes},
    // Receive path in order, including a read of the empty queue.
    {uttrb_pkg::OP_RX_BYTE,    8'hA5, 8'h00, 1'b0, NoRes},
    {uttrb_pkg::OP_RX_BYTE,    8'hFF, 8'hFF, 1'b0, NoRes},
    {uttrb_pkg::OP_RX_READ,    8'h00, 8'h00, 1'b0, NoRes},
    {uttrb_pkg::OP_RX_BYTE,    8'h00, 8'h00, 1'b0, NoRes},
    {uttrb_pkg::OP_RX_READ,    8'h00, 8'h00, 1'b0, NoRes},
    {uttrb_pkg::OP_RX_READ,    8'hFF, 8'hFF, 1'b0, NoRes},
    {uttrb_pkg::OP_RX_READ,    8'h00, 8'h00, 1'b1,
     uttrb_pkg::ST_EMPTY,    8'h00, 1'b0, 8'h00, 1'b0, 6'd0, 6'd0},
    // Operation codes outside the defined set must leave the state alone.
    {3'd5,          8'hFF, 8'hFF, 1'b0, NoRes},
    {3'd6,          8'h00, 8'h00, 1'b0, NoRes},
    {3'd7,          8'h3C, 8'hC3, 1'b0, NoRes}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  uttrb_evt_if evt_if ();
  uttrb_res_if res_if ();

  uart_tx_rx_ring_buffers #(
    .BUFFER_LOG2(RingLog2)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt_if),
    .res_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: a copy of both rings, their indices and the
  // transmitter running flag. Indices are RingLog2 bits wide so that they
  // wrap on their own.
  logic [7:0]          tx_ring [1 << RingLog2];
  logic [7:0]          rx_ring [1 << RingLog2];
  logic [RingLog2-1:0] tx_wr, tx_rd, rx_wr, rx_rd;
  logic                tx_running;

  // Results owed by the block, oldest first.
  uttrb_pkg::res_t pending_results [$];

  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned events_sent;
  int unsigned full_drops, empty_reads, reserve_refusals;
  int unsigned tx_peak, rx_peak;
  bit          idle_on;
  bit          stall_on;

  function automatic int unsigned tx_fill();
    logic [RingLog2-1:0] diff;
    diff = tx_wr - tx_rd;
    return diff;
  endfunction

  function automatic int unsigned rx_fill();
    logic [RingLog2-1:0] diff;
    diff = rx_wr - rx_rd;
    return diff;
  endfunction

  // Applies one event to the predictor state and returns the result beat
  // the block owes for it.
  function automatic uttrb_pkg::res_t ring_buffer_outcome(uttrb_pkg::evt_t ev);
    uttrb_pkg::res_t r;
    r = '0;
    r.status = uttrb_pkg::ST_OK;
    case (ev.operation)
      uttrb_pkg::OP_TX_RESERVE: begin
        if (RingCap - tx_fill() < ev.count) r.status = uttrb_pkg::ST_NO_SPACE;
      end
      uttrb_pkg::OP_TX_PUSH: begin
        if (tx_fill() == RingCap) begin
          r.status = uttrb_pkg::ST_FULL;
        end else begin
          tx_ring[tx_wr] = ev.data;
          tx_wr++;
        end
        // An idle transmitter is kicked off even when the byte was dropped.
        if (!tx_running) begin
          tx_running = 1'b1;
          if (tx_fill() != 0) begin
            r.line_valid = 1'b1;
            r.line_byte  = tx_ring[tx_rd];
            tx_rd++;
          end
        end
      end
      uttrb_pkg::OP_TX_DONE: begin
        if (tx_fill() != 0) begin
          tx_running   = 1'b1;
          r.line_valid = 1'b1;
          r.line_byte  = tx_ring[tx_rd];
          tx_rd++;
        end else begin
          tx_running = 1'b0;
        end
      end
      uttrb_pkg::OP_RX_BYTE: begin
        if (rx_fill() == RingCap) begin
          r.status = uttrb_pkg::ST_FULL;
        end else begin
          rx_ring[rx_wr] = ev.data;
          rx_wr++;
        end
      end
      uttrb_pkg::OP_RX_READ: begin
        if (rx_fill() == 0) begin
          r.status = uttrb_pkg::ST_EMPTY;
        end else begin
          r.read_data = rx_ring[rx_rd];
          rx_rd++;
        end
      end
      default: ;
    endcase
    r.tx_busy  = tx_running;
    r.tx_level = uttrb_pkg::LevelWidth'(tx_fill());
    r.rx_level = uttrb_pkg::LevelWidth'(rx_fill());
    return r;
  endfunction

  // Draws one random event shaped by the current traffic mode. Reserve
  // counts mostly sit right around the free transmit space, where the
  // ok / no-space decision flips.
  function automatic uttrb_pkg::evt_t draw_event(traffic_mode_e mode);
    uttrb_pkg::evt_t ev;
    int   roll;
    int   edge_count;
    roll = $urandom_range(0, 99);
    ev.data  = 8'($urandom_range(0, 255));
    ev.count = 8'($urandom_range(0, 255));
    case (mode)
      FILL_TX:  ev.operation = roll < 72 ? uttrb_pkg::OP_TX_PUSH :
                               roll < 80 ? uttrb_pkg::OP_TX_DONE :
                               roll < 92 ? uttrb_pkg::OP_TX_RESERVE :
                               roll < 95 ? uttrb_pkg::OP_RX_BYTE :
                               uttrb_pkg::OP_RX_READ;
      DRAIN_TX: ev.operation = roll < 65 ? uttrb_pkg::OP_TX_DONE :
                               roll < 78 ? uttrb_pkg::OP_TX_PUSH :
                               roll < 92 ? uttrb_pkg::OP_TX_RESERVE :
                               roll < 95 ? uttrb_pkg::OP_RX_BYTE :
                               uttrb_pkg::OP_RX_READ;
      FILL_RX:  ev.operation = roll < 75 ? uttrb_pkg::OP_RX_BYTE :
                               roll < 85 ? uttrb_pkg::OP_RX_READ :
                               roll < 90 ? uttrb_pkg::OP_TX_RESERVE :
                               roll < 95 ? uttrb_pkg::OP_TX_PUSH :
                               uttrb_pkg::OP_TX_DONE;
      DRAIN_RX: ev.operation = roll < 70 ? uttrb_pkg::OP_RX_READ :
                               roll < 82 ? uttrb_pkg::OP_RX_BYTE :
                               roll < 88 ? uttrb_pkg::OP_TX_RESERVE :
                               roll < 94 ? uttrb_pkg::OP_TX_PUSH :
                               uttrb_pkg::OP_TX_DONE;
      default:  ev.operation = 3'($urandom_range(0, 4));
    endcase
    // A sprinkle of undefined operation codes as noise.
    if ($urandom_range(0, 49) == 0) ev.operation = 3'($urandom_range(5, 7));
    if (ev.operation == uttrb_pkg::OP_TX_RESERVE && $urandom_range(0, 2) != 0) begin
      edge_count = int'(RingCap - tx_fill()) + int'($urandom_range(0, 2)) - 1;
      if (edge_count < 0) edge_count = 0;
      ev.count = 8'(edge_count);
    end
    return ev;
  endfunction

  // Offers one event beat after a random gap while idle_on is set and holds it
  // until the block takes it. Called and returning at a falling edge, so valid
  // stays high without a dip when the next beat follows with no gap.
  task automatic send_event(input uttrb_pkg::evt_t ev, input logic typed,
                            input uttrb_pkg::res_t want);
    int              gap;
    uttrb_pkg::res_t predicted;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      evt_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    evt_if.valid   = 1'b1;
    evt_if.payload = ev;
    forever begin
      @(posedge clk_i);
      if (evt_if.ready) break;
    end
    // The beat was taken at this edge, so the predictor moves now.
    predicted = ring_buffer_outcome(ev);
    pending_results.push_back(typed ? want : predicted);
    events_sent++;
    if (tx_fill() > tx_peak) tx_peak = tx_fill();
    if (rx_fill() > rx_peak) rx_peak = rx_fill();
    @(negedge clk_i);
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("result beat %0d: %s expected 0x%0h, got 0x%0h",
                 beats_checked, field, want, got);
      end
    end
  endtask

  // Result checker. Every beat taken by the sink is matched against the
  // oldest result still owed; a beat with nothing owed is a failure too.
  always @(posedge clk_i) begin
    uttrb_pkg::res_t want;
    uttrb_pkg::res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result beat %0d arrived with nothing owed: 0x%08h",
                   beats_checked, got);
        end
      end else begin
        want = pending_results.pop_front();
        compare_field("status",     want.status,     got.status);
        compare_field("read_data",  want.read_data,  got.read_data);
        compare_field("line_valid", want.line_valid, got.line_valid);
        compare_field("line_byte",  want.line_byte,  got.line_byte);
        compare_field("tx_busy",    want.tx_busy,    got.tx_busy);
        compare_field("tx_level",   want.tx_level,   got.tx_level);
        compare_field("rx_level",   want.rx_level,   got.rx_level);
      end
      if (got.status == uttrb_pkg::ST_FULL) full_drops++;
      if (got.status == uttrb_pkg::ST_EMPTY) empty_reads++;
      if (got.status == uttrb_pkg::ST_NO_SPACE) reserve_refusals++;
      beats_checked++;
    end
  end

  // Result sink. Before each beat it stalls for a random number of cycles;
  // now and then it switches into stretches with no stalls at all.
  initial begin
    int stall;
    res_if.ready = 1'b0;
    stall_on     = 1'b1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) stall_on = !stall_on;
      stall = stall_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      forever begin
        @(posedge clk_i);
        if (res_if.valid) break;
      end
      @(negedge clk_i);
    end
  end

  // Stimulus: reset, the directed table, then random episodes until enough
  // defined events have gone in.
  initial begin
    traffic_mode_e   mode;
    int unsigned     random_events;
    int unsigned     episode_len;
    uttrb_pkg::evt_t ev;
    evt_if.valid   = 1'b0;
    evt_if.payload = '0;
    rst_ni         = 1'b0;
    tx_wr = '0;
    tx_rd = '0;
    rx_wr = '0;
    rx_rd = '0;
    tx_running       = 1'b0;
    mismatches       = 0;
    beats_checked    = 0;
    events_sent      = 0;
    full_drops       = 0;
    empty_reads      = 0;
    reserve_refusals = 0;
    tx_peak          = 0;
    rx_peak          = 0;
    idle_on          = 1'b1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (Directed[i]) begin
      send_event(Directed[i].ev, Directed[i].typed, Directed[i].want);
    end

    random_events = 0;
    while (random_events < RandomEvents) begin
      mode        = traffic_mode_e'($urandom_range(0, 4));
      episode_len = $urandom_range(20, 110);
      // About one episode in four runs the sender back to back.
      idle_on     = ($urandom_range(0, 3) != 0);
      repeat (episode_len) begin
        ev = draw_event(mode);
        send_event(ev, 1'b0, NoRes);
        if (ev.operation <= uttrb_pkg::OP_RX_READ) random_events++;
      end
    end
    evt_if.valid = 1'b0;

    // Wait for every owed beat, then a few more cycles to catch strays.
    wait (pending_results.size() == 0);
    repeat (12) @(posedge clk_i);

    $display("checked %0d result beats for %0d events: %0d full drops, %0d empty reads,",
             beats_checked, events_sent, full_drops, empty_reads);
    $display("%0d reserve refusals; peak levels tx %0d, rx %0d",
             reserve_refusals, tx_peak, rx_peak);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(3_000_000);
    $display("timeout with %0d results still owed", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/uttrb_pkg.sv
hw/rtl/uttrb_if.sv
hw/rtl/uart_tx_rx_ring_buffers.sv
dv/testbench.sv
